FILE: sv/jioc_pkg.sv
// Shared constants, types and codes for the joint integral offset controller.
// Used by jioc_divider and joint_integral_offset_controller_unit; depends on nothing.
package jioc_pkg;

  localparam int HISTORY_DEPTH       = 8;
  localparam int RESET_WINDOW_CYCLES = 25;

  localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = 17 + $clog2(HISTORY_DEPTH);
  localparam int DIV_CW  = $clog2(SUM_W + 1);
  localparam int ERR_W   = 17;

  typedef enum logic [2:0] {
    CFG_WALK_GAIN_NEG  = 3'd0,
    CFG_WALK_GAIN_POS  = 3'd1,
    CFG_STAND_GAIN_NEG = 3'd2,
    CFG_STAND_GAIN_POS = 3'd3,
    CFG_UNWIND_GAIN    = 3'd4,
    CFG_INTEGRAL_LIMIT = 3'd5,
    CFG_RESET_STEP     = 3'd6,
    CFG_IS_LEG_JOINT   = 3'd7
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_GATE,
    ST_UNW_MUL,
    ST_UNW,
    ST_GAIN_MUL,
    ST_INT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [FILL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/jioc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module jioc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/jioc_divider.sv
// Restoring bit-serial divider for the error history average, one quotient bit per cycle.
// Depends on jioc_pkg for widths and the request and response structs.
module jioc_divider (
  input  logic                clk,
  input  logic                rst,
  input  jioc_pkg::div_req_t  req,
  output jioc_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [jioc_pkg::DIV_CW-1:0]   cnt;
  logic [jioc_pkg::FILL_W-1:0]   rem;
  logic [jioc_pkg::FILL_W-1:0]   dvs;
  logic [jioc_pkg::SUM_W-1:0]    quo;
  logic [jioc_pkg::FILL_W:0]     shifted;
  logic [jioc_pkg::FILL_W:0]     diff;
  logic                          fits;

  assign shifted = {rem, quo[jioc_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = !diff[jioc_pkg::FILL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= jioc_pkg::DIV_CW'(jioc_pkg::SUM_W);
        rem  <= '0;
        dvs  <= req.divisor;
        quo  <= req.dividend;
      end else if (busy) begin
        rem <= fits ? diff[jioc_pkg::FILL_W-1:0] : shifted[jioc_pkg::FILL_W-1:0];
        quo <= {quo[jioc_pkg::SUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == jioc_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < dvs)
    else $error("Partial remainder reached the divisor.");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy)
    else $error("Divider did not start.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("Divider finished without running.");

endmodule

FILE: sv/joint_integral_offset_controller_unit.sv
// One input beat is taken only while the unit is idle and yields one result beat of the
// updated integral offset. A disabled joint skips from acceptance straight to the done state.
// Otherwise the history is summed one entry a cycle, a nonempty history is averaged by a
// bit-serial divider, and one shared multiplier then serves the unwind and gain products
// in turn, each only where the gate steps call for it.
// A finished result waits in the output register while the next beat is accepted.
// Configuration writes are always ready; write them only while the unit is idle.
// Depends on jioc_pkg, jioc_ram and jioc_divider.
module joint_integral_offset_controller_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               phase_started,
  input  logic               left_phase,
  input  logic               walking,
  input  logic               is_support_knee,
  input  logic               joint_disabled,
  input  logic signed [15:0] target_angle,
  input  logic signed [15:0] measured_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] offset_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  jioc_pkg::state_t state;
  jioc_pkg::state_t state_next;

  logic signed [15:0] walk_gain_neg;
  logic signed [15:0] walk_gain_pos;
  logic signed [15:0] stand_gain_neg;
  logic signed [15:0] stand_gain_pos;
  logic [14:0]        unwind_gain;
  logic [14:0]        integral_limit;
  logic [14:0]        reset_step;
  logic               is_leg_joint;

  logic signed [15:0]            integral;
  logic                          reset_pending;
  logic                          latched_walking;
  logic                          latched_left;
  logic [15:0]                   cycles_since_switch;
  logic [jioc_pkg::FILL_W-1:0]   history_fill;
  logic [jioc_pkg::HIST_AW-1:0]  history_head;

  logic signed [16:0]               err;
  logic signed [15:0]               factor;
  logic signed [17:0]               err_change;
  logic signed [jioc_pkg::SUM_W-1:0] sum;
  logic [jioc_pkg::FILL_W-1:0]      rd_idx;
  logic                             rd_pend;
  logic signed [35:0]               prod;
  logic                             add_term;

  logic                   in_fire;
  logic                   out_free;
  logic                   phase_switch;
  logic                   walk_acc;
  logic signed [16:0]     err_in;
  logic signed [15:0]     factor_in;

  logic                              rd_issue;
  logic                              sum_done;
  logic [16:0]                       ram_rdata;
  logic signed [jioc_pkg::SUM_W-1:0] rdata_ext;
  logic                              sum_neg;
  logic [jioc_pkg::SUM_W-1:0]        sum_mag;
  logic signed [16:0]                q_pos;
  logic signed [16:0]                avg;
  logic signed [17:0]                err18;
  logic signed [17:0]                avg18;
  jioc_pkg::div_req_t                div_req;
  jioc_pkg::div_rsp_t                div_rsp;

  logic                   f_pos;
  logic                   f_zero;
  logic                   oz_pre;
  logic                   window_open;
  logic                   rp_gate;
  logic                   unw_gate;
  logic                   reset_prev;
  logic signed [16:0]     i17;
  logic signed [16:0]     rs17;
  logic signed [16:0]     c17;
  logic signed [15:0]     integ1;
  logic                   oz_post;
  logic                   cond2;

  logic signed [18:0]     mul_a;
  logic signed [16:0]     mul_b;
  logic signed [35:0]     prod_round;
  logic signed [21:0]     u22;
  logic signed [21:0]     i22;
  logic signed [21:0]     c22;
  logic signed [15:0]     integ2;
  logic                   gcond;

  logic signed [17:0]     t18;
  logic signed [17:0]     s18;
  logic signed [17:0]     lim18;
  logic signed [15:0]     integ3;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != jioc_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign phase_switch = (latched_walking && (latched_left != left_phase)) ||
                        (!latched_walking && walking);
  assign walk_acc  = phase_started ? walking : latched_walking;
  assign err_in    = $signed({target_angle[15], target_angle}) -
                     $signed({measured_angle[15], measured_angle});
  assign factor_in = walk_acc ? (err_in[16] ? walk_gain_neg : walk_gain_pos)
                              : (err_in[16] ? stand_gain_neg : stand_gain_pos);

  assign rd_issue  = rd_idx < history_fill;
  assign sum_done  = !rd_issue && !rd_pend;
  assign rdata_ext = jioc_pkg::SUM_W'($signed(ram_rdata));
  assign sum_neg   = sum[jioc_pkg::SUM_W-1];
  assign sum_mag   = sum_neg ? (~sum + 1'b1) : sum;
  assign q_pos     = $signed({1'b0, div_rsp.quotient[15:0]});
  assign avg       = sum_neg ? -q_pos : q_pos;
  assign err18     = $signed({err[16], err});
  assign avg18     = $signed({avg[16], avg});

  assign div_req.start    = (state == jioc_pkg::ST_SUM) && sum_done && (history_fill != '0);
  assign div_req.dividend = sum_mag;
  assign div_req.divisor  = history_fill;

  jioc_ram #(
    .WIDTH(jioc_pkg::ERR_W),
    .DEPTH(jioc_pkg::HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (state == jioc_pkg::ST_GATE),
    .waddr (history_head),
    .wdata (err),
    .raddr (rd_idx[jioc_pkg::HIST_AW-1:0]),
    .rdata (ram_rdata)
  );

  jioc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign f_pos       = !factor[15] && (factor != '0);
  assign f_zero      = (factor == '0);
  assign oz_pre      = (err == '0) || (integral == '0) || (err[16] != integral[15]);
  assign window_open = cycles_since_switch < 16'(jioc_pkg::RESET_WINDOW_CYCLES);
  assign rp_gate     = reset_pending && window_open && (integral != '0) && oz_pre && f_pos;
  assign unw_gate    = (unwind_gain != '0) && (err_change != '0) && (integral != '0) &&
                       (err_change[17] != integral[15]);
  assign reset_prev  = (rp_gate && is_leg_joint) || f_zero;
  assign i17         = $signed({integral[15], integral});
  assign rs17        = $signed({2'b00, reset_step});
  assign c17         = (i17 > rs17) ? rs17 : ((i17 < -rs17) ? -rs17 : i17);
  assign integ1      = reset_prev ? 16'(i17 - c17) : integral;
  assign oz_post     = (err == '0) || (integ1 == '0) || (err[16] != integ1[15]);
  assign cond2       = !reset_prev || (oz_post && f_pos);

  assign mul_a = (state == jioc_pkg::ST_UNW_MUL) ? -$signed({err_change[17], err_change})
                                                 : $signed({{2{err[16]}}, err});
  assign mul_b = (state == jioc_pkg::ST_UNW_MUL) ? $signed({2'b00, unwind_gain})
                                                 : $signed({factor[15], factor});

  assign prod_round = (prod + 36'sd8192) >>> 14;
  assign u22        = prod_round[21:0];
  assign i22        = 22'(integral);
  assign c22        = (u22 >= 22'sd0)
                      ? ((i22 < 22'sd0) ? 22'sd0 : ((i22 > u22) ? u22 : i22))
                      : ((i22 > 22'sd0) ? 22'sd0 : ((i22 < u22) ? u22 : i22));
  assign integ2     = 16'(i22 - c22);
  assign gcond      = (err != '0) && (integ2 != '0) && (err[16] != integ2[15]);

  assign t18    = !add_term ? 18'sd0
                : (prod_round > 36'sd32767) ? 18'sd32767
                : (prod_round < -36'sd32768) ? -18'sd32768
                : 18'(prod_round);
  assign s18    = 18'(integral) + t18;
  assign lim18  = $signed({3'b000, integral_limit});
  assign integ3 = (s18 > lim18) ? 16'(lim18) : ((s18 < -lim18) ? 16'(-lim18) : 16'(s18));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jioc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      jioc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = joint_disabled ? jioc_pkg::ST_DONE : jioc_pkg::ST_SUM;
        end
      end
      jioc_pkg::ST_SUM: begin
        if (sum_done) begin
          state_next = (history_fill == '0) ? jioc_pkg::ST_GATE : jioc_pkg::ST_DIV;
        end
      end
      jioc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = jioc_pkg::ST_GATE;
        end
      end
      jioc_pkg::ST_GATE: begin
        if (!cond2) begin
          state_next = jioc_pkg::ST_DONE;
        end else if (unw_gate) begin
          state_next = jioc_pkg::ST_UNW_MUL;
        end else begin
          state_next = jioc_pkg::ST_GAIN_MUL;
        end
      end
      jioc_pkg::ST_UNW_MUL: state_next = jioc_pkg::ST_UNW;
      jioc_pkg::ST_UNW: begin
        state_next = gcond ? jioc_pkg::ST_GAIN_MUL : jioc_pkg::ST_INT;
      end
      jioc_pkg::ST_GAIN_MUL: state_next = jioc_pkg::ST_INT;
      jioc_pkg::ST_INT: state_next = jioc_pkg::ST_DONE;
      jioc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = jioc_pkg::ST_IDLE;
        end
      end
      default: state_next = jioc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_gain_neg       <= '0;
      walk_gain_pos       <= '0;
      stand_gain_neg      <= '0;
      stand_gain_pos      <= '0;
      unwind_gain         <= '0;
      integral_limit      <= '0;
      reset_step          <= '0;
      is_leg_joint        <= 1'b0;
      integral            <= '0;
      reset_pending       <= 1'b0;
      latched_walking     <= 1'b0;
      latched_left        <= 1'b0;
      cycles_since_switch <= 16'hFFFF;
      history_fill        <= '0;
      history_head        <= '0;
      out_valid           <= 1'b0;
      rd_pend             <= 1'b0;
      rd_idx              <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jioc_pkg::CFG_WALK_GAIN_NEG:  walk_gain_neg  <= cfg_data;
          jioc_pkg::CFG_WALK_GAIN_POS:  walk_gain_pos  <= cfg_data;
          jioc_pkg::CFG_STAND_GAIN_NEG: stand_gain_neg <= cfg_data;
          jioc_pkg::CFG_STAND_GAIN_POS: stand_gain_pos <= cfg_data;
          jioc_pkg::CFG_UNWIND_GAIN:    unwind_gain    <= cfg_data[14:0];
          jioc_pkg::CFG_INTEGRAL_LIMIT: integral_limit <= cfg_data[14:0];
          jioc_pkg::CFG_RESET_STEP:     reset_step     <= cfg_data[14:0];
          jioc_pkg::CFG_IS_LEG_JOINT:   is_leg_joint   <= cfg_data[0];
          default: ;
        endcase
      end

      if ((state == jioc_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        jioc_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (phase_started) begin
              cycles_since_switch <= '0;
              if (phase_switch) begin
                reset_pending <= !is_support_knee;
              end
              latched_walking <= walking;
              latched_left    <= left_phase;
            end else if (cycles_since_switch != 16'hFFFF) begin
              cycles_since_switch <= cycles_since_switch + 1'b1;
            end
            if (joint_disabled) begin
              integral <= '0;
            end
            err     <= err_in;
            factor  <= factor_in;
            sum     <= '0;
            rd_idx  <= '0;
            rd_pend <= 1'b0;
          end
        end
        jioc_pkg::ST_SUM: begin
          rd_idx  <= rd_idx + jioc_pkg::FILL_W'(rd_issue);
          rd_pend <= rd_issue;
          if (rd_pend) begin
            sum <= sum + rdata_ext;
          end
          if (sum_done) begin
            err_change <= err18;
          end
        end
        jioc_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            err_change <= err18 - avg18;
          end
        end
        jioc_pkg::ST_GATE: begin
          reset_pending <= rp_gate;
          integral      <= integ1;
          history_head  <= (history_head == jioc_pkg::HIST_AW'(jioc_pkg::HISTORY_DEPTH - 1))
                           ? '0 : history_head + 1'b1;
          if (history_fill < jioc_pkg::FILL_W'(jioc_pkg::HISTORY_DEPTH)) begin
            history_fill <= history_fill + 1'b1;
          end
        end
        jioc_pkg::ST_UNW_MUL: begin
          prod <= mul_a * mul_b;
        end
        jioc_pkg::ST_UNW: begin
          integral <= integ2;
          add_term <= 1'b0;
        end
        jioc_pkg::ST_GAIN_MUL: begin
          prod     <= mul_a * mul_b;
          add_term <= 1'b1;
        end
        jioc_pkg::ST_INT: begin
          integral <= integ3;
        end
        jioc_pkg::ST_DONE: begin
          if (out_free) begin
            offset_angle <= integral;
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != jioc_pkg::ST_IDLE)
    else $error("Unit returned to idle right after accepting a beat.");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    history_fill <= jioc_pkg::FILL_W'(jioc_pkg::HISTORY_DEPTH))
    else $error("History fill count exceeded the history depth.");

  a_head_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (history_fill < jioc_pkg::FILL_W'(jioc_pkg::HISTORY_DEPTH)) |->
      (history_head == history_fill[jioc_pkg::HIST_AW-1:0]))
    else $error("History write pointer out of step with the fill count.");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == jioc_pkg::ST_DIV)
    else $error("Average arrived outside the averaging step.");

endmodule
